// ===== rtl/core/incremental_pid_speed_drive_assert.svh =====
// Assertion helpers for the PID speed drive. Each one is clocked on i_clk and
// is switched off while the synchronous reset is held.
`ifndef INCREMENTAL_PID_SPEED_DRIVE_ASSERT_SVH
`define INCREMENTAL_PID_SPEED_DRIVE_ASSERT_SVH

`ifndef SYNTHESIS

// Checks a property on every clock edge outside of reset.
`define IPSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checks that a condition never holds on a clock edge outside of reset.
`define IPSD_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`else

`define IPSD_ASSERT(lbl, prop, msg)
`define IPSD_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ===== rtl/core/ipsd_pkg.sv =====
package ipsd_pkg;

    // Field widths of the ports and the configuration registers.
    localparam int GAIN_W    = 24;
    localparam int LIM_W     = 10;
    localparam int SPD_W     = 13;
    localparam int CFG_IDX_W = 3;

    // Internal widths of the error terms and of the gain products.
    localparam int ERR_W = SPD_W + 1;
    localparam int DP_W  = ERR_W + 1;
    localparam int DD_W  = ERR_W + 2;
    localparam int PP_W  = GAIN_W + 1 + DP_W;
    localparam int PI_W  = GAIN_W + 1 + ERR_W;
    localparam int PD_W  = GAIN_W + 1 + DD_W;
    localparam int INC_W = PD_W + 2;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP_GAIN   = 3'd0,
        CFG_KI_GAIN   = 3'd1,
        CFG_KD_GAIN   = 3'd2,
        CFG_DRIVE_MIN = 3'd3,
        CFG_DRIVE_MAX = 3'd4
    } t_cfg_idx;

    // Current controller settings as seen by the datapath.
    typedef struct packed {
        logic [GAIN_W-1:0] kp_gain;
        logic [GAIN_W-1:0] ki_gain;
        logic [GAIN_W-1:0] kd_gain;
        logic [LIM_W-1:0]  drive_min;
        logic [LIM_W-1:0]  drive_max;
    } t_cfg;

endpackage

// ===== rtl/core/ipsd_cfg_regs.sv =====
module ipsd_cfg_regs
    import ipsd_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [GAIN_W-1:0]    i_cfg_data,
    output t_cfg                 o_cfg
);

    // Reset gains are 5.0, 4.0 and 2.0 in the chosen fixed-point format.
    localparam logic [GAIN_W-1:0] KP_RST = GAIN_W'(64'(5) << FRAC_BITS);
    localparam logic [GAIN_W-1:0] KI_RST = GAIN_W'(64'(4) << FRAC_BITS);
    localparam logic [GAIN_W-1:0] KD_RST = GAIN_W'(64'(2) << FRAC_BITS);
    localparam logic [LIM_W-1:0]  MIN_RST = LIM_W'(200);
    localparam logic [LIM_W-1:0]  MAX_RST = LIM_W'(900);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the register index; writes beyond the list are dropped.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_KP_GAIN:   n_cfg.kp_gain   = i_cfg_data;
                CFG_KI_GAIN:   n_cfg.ki_gain   = i_cfg_data;
                CFG_KD_GAIN:   n_cfg.kd_gain   = i_cfg_data;
                CFG_DRIVE_MIN: n_cfg.drive_min = i_cfg_data[LIM_W-1:0];
                CFG_DRIVE_MAX: n_cfg.drive_max = i_cfg_data[LIM_W-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_gain   <= KP_RST;
            r_cfg.ki_gain   <= KI_RST;
            r_cfg.kd_gain   <= KD_RST;
            r_cfg.drive_min <= MIN_RST;
            r_cfg.drive_max <= MAX_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/incremental_pid_speed_drive.sv =====
// Channel   Direction  Handshake                  Payload
// in        sink       i_in_valid / o_in_stall    i_measured_speed, i_target_speed
// out       source     o_out_valid / i_out_stall  o_drive_value
// cfg       sink       i_cfg_we                   i_cfg_index, i_cfg_data
//
// One sample per cycle is accepted while o_in_stall is low; a result passes through each stage in turn.
// The stages are input register, gain products, increment sum, and the clamped accumulator.
// The accumulator loop closes through r_accum alone, so back-to-back samples need no wait.
// Synchronous active-low reset restores the gains, limits, error history and accumulator.
// A stalled result holds the stages behind it; o_in_stall rises once all four are full.
`include "incremental_pid_speed_drive_assert.svh"

module incremental_pid_speed_drive
    import ipsd_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [SPD_W-1:0] i_measured_speed,
    input  logic signed [SPD_W-1:0] i_target_speed,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [LIM_W-1:0]        o_drive_value,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [GAIN_W-1:0]       i_cfg_data
);

    localparam int ACC_W = LIM_W + FRAC_BITS;
    localparam int SUM_W = INC_W + 1;
    // 0.01 rounded to the nearest step of the fixed-point format.
    localparam longint BIAS_VAL = ((longint'(1) << FRAC_BITS) + 50) / 100;
    localparam logic [ACC_W-1:0] ACC_RST = {LIM_W'(500), {FRAC_BITS{1'b0}}};
    localparam logic signed [ERR_W-1:0] ERR_RST = ERR_W'(1);

    t_cfg w_cfg;

    // Stage valid flags and the moves between stages.
    logic r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    logic w_a_free, w_b_free, w_c_free, w_d_free;
    logic w_in_xfer, w_a_move, w_b_move, w_c_move;
    logic w_all_full;

    // Stage payloads.
    logic signed [SPD_W-1:0] r_a_meas, r_a_targ;
    logic signed [PP_W-1:0]  r_b_pp;
    logic signed [PI_W-1:0]  r_b_pi;
    logic signed [PD_W-1:0]  r_b_pd;
    logic signed [INC_W-1:0] r_c_inc;
    logic [ACC_W-1:0]        r_accum;
    logic [ACC_W-1:0]        n_accum;

    // Error history.
    logic signed [ERR_W-1:0] r_last_err, r_prev_err;

    logic signed [ERR_W-1:0] w_err;
    logic signed [DP_W-1:0]  w_dp;
    logic signed [DD_W-1:0]  w_dd;
    logic signed [PP_W-1:0]  w_pp;
    logic signed [PI_W-1:0]  w_pi;
    logic signed [PD_W-1:0]  w_pd;
    logic signed [INC_W-1:0] w_inc;
    logic signed [SUM_W-1:0] w_sum, w_hi, w_lo, w_clip_hi, w_clip_lo;

    ipsd_cfg_regs #(
        .FRAC_BITS(FRAC_BITS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // A stage can load when it is empty or its content moves on this cycle.
    assign w_d_free  = !r_d_valid || !i_out_stall;
    assign w_c_move  = r_c_valid && w_d_free;
    assign w_c_free  = !r_c_valid || w_d_free;
    assign w_b_move  = r_b_valid && w_c_free;
    assign w_b_free  = !r_b_valid || w_c_free;
    assign w_a_move  = r_a_valid && w_b_free;
    assign w_a_free  = !r_a_valid || w_b_free;
    assign o_in_stall = !w_a_free;
    assign w_in_xfer  = i_in_valid && w_a_free;
    assign w_all_full = r_a_valid && r_b_valid && r_c_valid && r_d_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (w_a_free) begin
                r_a_valid <= i_in_valid;
            end
            if (w_b_free) begin
                r_b_valid <= r_a_valid;
            end
            if (w_c_free) begin
                r_c_valid <= r_b_valid;
            end
            if (w_d_free) begin
                r_d_valid <= r_c_valid;
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_a_meas <= i_measured_speed;
            r_a_targ <= i_target_speed;
        end
    end

    // Error, its first and second differences, and the three gain products.
    assign w_err = ERR_W'(r_a_targ) - ERR_W'(r_a_meas);
    assign w_dp  = DP_W'(w_err) - DP_W'(r_last_err);
    assign w_dd  = DD_W'(w_err) - (DD_W'(r_last_err) <<< 1) + DD_W'(r_prev_err);
    assign w_pp  = PP_W'($signed({1'b0, w_cfg.kp_gain})) * PP_W'(w_dp);
    assign w_pi  = PI_W'($signed({1'b0, w_cfg.ki_gain})) * PI_W'(w_err);
    assign w_pd  = PD_W'($signed({1'b0, w_cfg.kd_gain})) * PD_W'(w_dd);

    always_ff @(posedge i_clk) begin
        if (w_a_move) begin
            r_b_pp <= w_pp;
            r_b_pi <= w_pi;
            r_b_pd <= w_pd;
        end
    end

    // The history shifts as each sample enters the product stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_err <= ERR_RST;
            r_prev_err <= ERR_RST;
        end else if (w_a_move) begin
            r_prev_err <= r_last_err;
            r_last_err <= w_err;
        end
    end

    // Increment: sum of the products plus the fixed bias.
    assign w_inc = INC_W'(r_b_pp) + INC_W'(r_b_pi) + INC_W'(r_b_pd)
                 + $signed(INC_W'(BIAS_VAL));

    always_ff @(posedge i_clk) begin
        if (w_b_move) begin
            r_c_inc <= w_inc;
        end
    end

    // Accumulate, clamp to the upper limit, then to the lower limit.
    assign w_sum = $signed(SUM_W'(r_accum)) + SUM_W'(r_c_inc);
    assign w_hi  = $signed(SUM_W'({w_cfg.drive_max, {FRAC_BITS{1'b0}}}));
    assign w_lo  = $signed(SUM_W'({w_cfg.drive_min, {FRAC_BITS{1'b0}}}));
    assign w_clip_hi = (w_sum > w_hi) ? w_hi : w_sum;
    assign w_clip_lo = (w_clip_hi < w_lo) ? w_lo : w_clip_hi;
    assign n_accum   = w_clip_lo[ACC_W-1:0];

    // The accumulator doubles as the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= ACC_RST;
        end else if (w_c_move) begin
            r_accum <= n_accum;
        end
    end

    assign o_out_valid   = r_d_valid;
    assign o_drive_value = r_accum[ACC_W-1:FRAC_BITS];

    // The input side stalls only when every stage holds a sample behind a stalled result.
    `IPSD_ASSERT(a_stall_full, o_in_stall |-> (w_all_full && i_out_stall), "stall with room")

    // The history shifts by exactly one place per sample.
    `IPSD_ASSERT(a_hist_shift, w_a_move |=> (r_prev_err == $past(r_last_err)), "no shift")

    // The accumulator changes only when a sample reaches the result stage.
    `IPSD_ASSERT(a_accum_hold, !w_c_move |=> $stable(r_accum), "accumulator moved")

    // A held result never advances the increment stage into it.
    `IPSD_ASSERT_NEVER(a_no_overrun, r_d_valid && i_out_stall && w_c_move, "result overwritten")

endmodule
